FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk.
`define TWS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tws: implication check failed");

// Invariant checked at every rising edge of clk.
`define TWS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tws: invariant check failed");

`endif

FILE: rtl/tws_pkg.sv
// ---------------------------------------------------------------------------
// tws_pkg
// Shared constants, request codes and structs of the trie word store.
// ---------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int ALPHABET   = 26;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int FREE_W = $clog2(NODE_COUNT + 1);
    localparam int IDX_W  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int ROW_W  = ALPHABET * NODE_W;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7a;

    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_SEARCH   = 2'd1,
        REQ_PREFIX   = 2'd2,
        REQ_RESERVED = 2'd3
    } req_t;

    typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

    typedef struct packed {
        req_t             req;
        logic             has_char;
        logic             letter_ok;
        logic [IDX_W-1:0] idx;
        logic             last;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] cursor;
        logic [FREE_W-1:0] next_free;
        logic              failed;
        logic              overflow;
    } walk_t;

    typedef struct packed {
        walk_t walk;
        logic  row_we;
        row_t  row_wdata;
    } step_t;

endpackage

`default_nettype wire

FILE: rtl/tws_ram.sv
// ---------------------------------------------------------------------------
// tws_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tws_step.sv
// ---------------------------------------------------------------------------
// tws_step
// One walk step: follow or allocate the child of the current node.
// ---------------------------------------------------------------------------
`default_nettype none

module tws_step (
    input  wire tws_pkg::item_t item,
    input  wire tws_pkg::row_t  row,
    input  wire tws_pkg::walk_t walk,
    output tws_pkg::step_t      step
);
    import tws_pkg::*;

    always_comb
    begin
        logic [NODE_W-1:0] child;

        child          = row[item.idx];
        step.walk      = walk;
        step.row_we    = 1'b0;
        step.row_wdata = row;

        if (item.has_char && item.req == REQ_INSERT)
        begin
            if (item.letter_ok && !walk.overflow)
            begin
                if (child == '0)
                begin
                    if (walk.next_free >= FREE_W'(NODE_COUNT))
                    begin
                        step.walk.overflow = 1'b1;
                    end
                    else
                    begin
                        child                   = walk.next_free[NODE_W-1:0];
                        step.walk.next_free     = walk.next_free + FREE_W'(1);
                        step.row_wdata[item.idx] = child;
                        step.row_we             = 1'b1;
                    end
                end
                if (!step.walk.overflow)
                begin
                    step.walk.cursor = child;
                end
            end
        end
        else if (item.has_char && (item.req == REQ_SEARCH || item.req == REQ_PREFIX)
                 && !walk.failed)
        begin
            if (!item.letter_ok || child == '0)
            begin
                step.walk.failed = 1'b1;
            end
            else
            begin
                step.walk.cursor = child;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/trie_word_store.sv
// ---------------------------------------------------------------------------
// trie_word_store
// Prefix tree over a to z in a node pool, one character per input transfer.
// ---------------------------------------------------------------------------
// Flow: one item at a time; each goes through a read-modify-write of the
//   child row memory, and a final item of an exact search also reads the end mark.
// Result: registered; for an exact search it waits on the end-mark read in ST_MARK.
// Reset: a clearing pass over all NODE_COUNT (1024) addresses zeroes the child rows
//   and end marks; no input is accepted until it completes.
`default_nettype none

`include "assert_macros.svh"

module trie_word_store (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,  // char_code[7:0], has_char[8], zero pad
    input  wire logic [1:0]           s_tuser,  // req_type[1:0]
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [7:0]           m_tdata   // hit[0], status[1], zero pad
);
    import tws_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MARK
    } state_t;

    state_t            state_reg,  state_next;
    logic [NODE_W-1:0] clr_addr_reg, clr_addr_next;
    item_t             item_reg,   item_next;
    walk_t             walk_reg,   walk_next;
    logic              pend_reg,   pend_next;
    logic              m_valid_reg, m_valid_next;
    logic              hit_reg,    hit_next;
    logic              status_reg, status_next;

    logic              accept;
    logic              res_load;
    logic [7:0]        ofs;
    row_t              row_q;
    logic [ROW_W-1:0]  row_rdata;
    logic              mark_q;
    step_t             step;
    logic              clearing;
    logic              exec;
    logic              mark_set;
    logic              mark_re;

    assign clearing = (state_reg == ST_CLEAR);
    assign exec     = (state_reg == ST_EXEC);
    assign s_tready = (state_reg == ST_IDLE) && !(m_valid_reg && !m_tready && s_tlast);
    assign accept   = s_tvalid && s_tready;
    assign ofs      = s_tdata[7:0] - CHAR_A;
    assign row_q    = row_t'(row_rdata);

    assign mark_set = exec && item_reg.last && item_reg.req == REQ_INSERT
                      && !step.walk.overflow;
    assign mark_re  = exec && item_reg.last && item_reg.req == REQ_SEARCH;

    tws_step u_step (
        .item (item_reg),
        .row  (row_q),
        .walk (walk_reg),
        .step (step)
    );

    tws_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODE_COUNT)
    ) u_row_ram (
        .clk   (clk),
        .we    (clearing || (exec && step.row_we)),
        .waddr (clearing ? clr_addr_reg : walk_reg.cursor),
        .wdata (clearing ? '0 : ROW_W'(step.row_wdata)),
        .re    (accept),
        .raddr (walk_reg.cursor),
        .rdata (row_rdata)
    );

    tws_ram #(
        .WIDTH (1),
        .DEPTH (NODE_COUNT)
    ) u_mark_ram (
        .clk   (clk),
        .we    (clearing || mark_set),
        .waddr (clearing ? clr_addr_reg : step.walk.cursor),
        .wdata (!clearing),
        .re    (mark_re),
        .raddr (step.walk.cursor),
        .rdata (mark_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        item_next     = item_reg;
        walk_next     = walk_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        status_next   = status_reg;
        res_load      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + NODE_W'(1);
                if (clr_addr_reg == NODE_W'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next.req       = req_t'(s_tuser);
                    item_next.has_char  = s_tdata[8];
                    item_next.letter_ok = (s_tdata[7:0] >= CHAR_A) && (s_tdata[7:0] <= CHAR_Z)
                                          && (ofs < 8'(ALPHABET));
                    item_next.idx       = ofs[IDX_W-1:0];
                    item_next.last      = s_tlast;
                    state_next          = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                walk_next  = step.walk;
                state_next = ST_IDLE;
                if (item_reg.last)
                begin
                    walk_next.cursor   = '0;
                    walk_next.failed   = 1'b0;
                    walk_next.overflow = 1'b0;
                    hit_next           = 1'b0;
                    status_next        = 1'b0;
                    case (item_reg.req)
                        REQ_INSERT:
                        begin
                            status_next = step.walk.overflow;
                            res_load    = 1'b1;
                        end
                        REQ_SEARCH:
                        begin
                            pend_next  = !step.walk.failed;
                            state_next = ST_MARK;
                        end
                        REQ_PREFIX:
                        begin
                            hit_next = !step.walk.failed;
                            res_load = 1'b1;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_MARK:
            begin
                hit_next    = pend_reg && mark_q;
                status_next = 1'b0;
                res_load    = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (res_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clr_addr_reg       <= '0;
            walk_reg.cursor    <= '0;
            walk_reg.next_free <= FREE_W'(1);
            walk_reg.failed    <= 1'b0;
            walk_reg.overflow  <= 1'b0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            walk_reg     <= walk_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        pend_reg   <= pend_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, status_reg, hit_reg};

    `TWS_ASSERT_ALWAYS(a_free_bound, walk_reg.next_free <= FREE_W'(NODE_COUNT))
    `TWS_ASSERT_IMP(a_cursor_alloc, state_reg == ST_IDLE,
                    FREE_W'(walk_reg.cursor) < walk_reg.next_free)
    `TWS_ASSERT_IMP(a_no_result_clobber, res_load, !m_valid_reg || m_tready)
    `TWS_ASSERT_IMP(a_clear_blocks_input, state_reg == ST_CLEAR,
                    !s_tready && !m_valid_reg)

endmodule

`default_nettype wire
